[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Request and response words, status and action codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int HANDLE_W = 16;
	localparam int KIND_W   = 8;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_HANDLE = 2'd1,
		ST_FULL       = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic [HANDLE_W-1:0]       item_handle;
		logic [KIND_W-1:0]         kind;
		logic signed [PRIO_W-1:0]  priority_req;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic [COUNT_W-1:0]        count;
		logic [HANDLE_W-1:0]       out_handle;
		logic [KIND_W-1:0]         out_kind;
		logic signed [PRIO_W-1:0]  out_priority;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch request word and per-entry compares
		logic exec;     // commit the operation and load the response
	} spq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free; // response register free or emptied this cycle
	} spq_stat_t;

endpackage

[sv/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl: queue operation sequencer
// Accepts a request word, then executes it once the response register can
// take the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output spq_pkg::spq_cmd_t   cmd,
	input  spq_pkg::spq_stat_t  stat
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the response register is free
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath: sorted shift array, compare row and response register
// Entries sit in ascending priority order, head at position 0. Each position
// compares its handle and priority against the request; insert shifts the
// tail back by one, remove shifts everything forward by one.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::req_t       req,
	output spq_pkg::rsp_t       rsp,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  spq_pkg::spq_cmd_t   cmd,
	output spq_pkg::spq_stat_t  stat
);

	localparam int HW = (HANDLE_BITS < spq_pkg::HANDLE_W) ? HANDLE_BITS : spq_pkg::HANDLE_W;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [HW-1:0]                   hdl_q [QUEUE_DEPTH];
	logic [spq_pkg::KIND_W-1:0]      knd_q [QUEUE_DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0] pri_q [QUEUE_DEPTH];
	logic [HW-1:0]                   hdl_d [QUEUE_DEPTH];
	logic [spq_pkg::KIND_W-1:0]      knd_d [QUEUE_DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0] pri_d [QUEUE_DEPTH];

	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          cnt_d;
	logic                   out_valid_q;
	spq_pkg::rsp_t          rsp_q;
	spq_pkg::rsp_t          rsp_d;

	spq_pkg::req_t          req_s1;
	logic [QUEUE_DEPTH-1:0] match_s1;
	logic [QUEUE_DEPTH-1:0] le_s1;
	logic [QUEUE_DEPTH-1:0] match_d;
	logic [QUEUE_DEPTH-1:0] le_d;

	logic [HW-1:0] new_hdl;
	logic          is_ins;
	logic          ins_ok;
	logic          rem_ok;
	logic          full;
	logic          empty;

	// compare row against the incoming word; only occupied positions count
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match_d[i] = (i < int'(cnt_q)) && (hdl_q[i] == req.item_handle[HW-1:0]);
			le_d[i]    = (i < int'(cnt_q)) && (pri_q[i] <= req.priority_req);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1   <= req;
			match_s1 <= match_d;
			le_s1    <= le_d;
		end
	end

	assign new_hdl = req_s1.item_handle[HW-1:0];
	assign is_ins  = (req_s1.action == spq_pkg::ACT_INSERT);
	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);

	always_comb begin
		ins_ok        = 1'b0;
		rem_ok        = 1'b0;
		rsp_d         = '0;
		rsp_d.status  = spq_pkg::ST_OK;
		priority if (is_ins && (new_hdl == '0 || |match_s1)) begin
			rsp_d.status = spq_pkg::ST_BAD_HANDLE;
		end else if (is_ins && full) begin
			rsp_d.status = spq_pkg::ST_FULL;
		end else if (is_ins) begin
			ins_ok = 1'b1;
		end else if (empty) begin
			rsp_d.status = spq_pkg::ST_EMPTY;
		end else begin
			rem_ok             = 1'b1;
			rsp_d.out_handle   = spq_pkg::HANDLE_W'(hdl_q[0]);
			rsp_d.out_kind     = knd_q[0];
			rsp_d.out_priority = pri_q[0];
		end
		priority if (ins_ok) begin
			cnt_d = cnt_q + CW'(1);
		end else if (rem_ok) begin
			cnt_d = cnt_q - CW'(1);
		end else begin
			cnt_d = cnt_q;
		end
		rsp_d.count = spq_pkg::COUNT_W'(cnt_d);
	end

	// next value of each position: the new entry goes to the first position
	// that is free or holds a priority above the request; all behind it moves back
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_pos
		logic [HW-1:0]                     prev_h;
		logic [spq_pkg::KIND_W-1:0]        prev_k;
		logic signed [spq_pkg::PRIO_W-1:0] prev_p;
		logic                              take_new;
		logic [HW-1:0]                     next_h;
		logic [spq_pkg::KIND_W-1:0]        next_k;
		logic signed [spq_pkg::PRIO_W-1:0] next_p;

		if (g == 0) begin : g_head
			assign prev_h   = new_hdl;
			assign prev_k   = req_s1.kind;
			assign prev_p   = req_s1.priority_req;
			assign take_new = 1'b1;
		end else begin : g_body
			assign prev_h   = hdl_q[g-1];
			assign prev_k   = knd_q[g-1];
			assign prev_p   = pri_q[g-1];
			assign take_new = le_s1[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign next_h = hdl_q[g];
			assign next_k = knd_q[g];
			assign next_p = pri_q[g];
		end else begin : g_mid
			assign next_h = hdl_q[g+1];
			assign next_k = knd_q[g+1];
			assign next_p = pri_q[g+1];
		end

		always_comb begin
			hdl_d[g] = hdl_q[g];
			knd_d[g] = knd_q[g];
			pri_d[g] = pri_q[g];
			if (ins_ok && !le_s1[g]) begin
				if (take_new) begin
					hdl_d[g] = new_hdl;
					knd_d[g] = req_s1.kind;
					pri_d[g] = req_s1.priority_req;
				end else begin
					hdl_d[g] = prev_h;
					knd_d[g] = prev_k;
					pri_d[g] = prev_p;
				end
			end else if (rem_ok) begin
				hdl_d[g] = next_h;
				knd_d[g] = next_k;
				pri_d[g] = next_p;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				hdl_q[i] <= hdl_d[i];
				knd_q[i] <= knd_d[i];
				pri_q[i] <= pri_d[i];
			end
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cnt_q <= cnt_d;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp           = rsp_q;
	assign rsp_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || rsp_ready;

endmodule

[sv/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, FIFO order among equal keys
// Insert places an entry after all queued entries of lower or equal priority;
// remove returns the head. Null or duplicate handles and a full queue are
// rejected; every word in yields one response word.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_ready   action, item_handle, kind, priority_req
//   rsp      out        rsp_valid/rsp_ready   status, count, out_handle, out_kind,
//                                             out_priority
//
// An operation has two steps: accepting the word and running the handle and
// priority compare across every queue position, then shifting the sorted
// array and loading the response register.
// A waiting response does not block the next accept; the execute cycle waits
// only while the response register is still full.
// Reset clears the count and rsp_valid; the entry array needs no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  spq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output spq_pkg::rsp_t  rsp
);

	spq_pkg::spq_cmd_t  cmd;
	spq_pkg::spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
